[hw/rtl/cba_pkg.sv]
// Shared constants, codes and types for the contiguous block allocator.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // Disk geometry and field widths
    localparam int DISK_BLOCKS = 64;
    localparam int BLK_W       = 6;
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 8;

    // Request codes
    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_REPLY = 2'd2
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/contiguous_block_allocator_top.sv]
// Contiguous block allocator: 64-block usage bitmap with allocate, release and query.
// A request taken while idle or in the reply cycle goes to the request registers, is checked in the execute
// cycle, and gives its result beat, done high, in the reply cycle; a new beat is also taken during the reply cycle.
// busy is high only in the execute cycle, where the bitmap mask test and update happen.
// Reset (rst_n low, asynchronous) frees every block and returns the controller to idle.
// The receiver cannot stall: each result is flagged by done for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_allocator_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 action,
    input  wire logic [cba_pkg::BLK_W-1:0]  start_block,
    input  wire logic [cba_pkg::LEN_W-1:0]  run_length,
    output logic                            done,
    output logic [1:0]                      status,
    output logic                            block_used
);

    cba_pkg::cmd_t cmd;

    // Controller
    cba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath
    cba_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .start_block (start_block),
        .run_length  (run_length),
        .status      (status),
        .block_used  (block_used)
    );

endmodule

`default_nettype wire

[hw/rtl/cba_ctrl.sv]
// Controller state machine: sequences request capture, execution and reply.
`timescale 1ns / 1ps
`default_nettype none

module cba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output cba_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);

    cba_pkg::state_t state_reg;
    cba_pkg::state_t state_next;
    logic            accept;

    // A new beat is taken whenever the block is not executing
    assign accept = start && !busy;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cba_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = cba_pkg::S_EXEC;
            end
            cba_pkg::S_EXEC:
            begin
                state_next = cba_pkg::S_REPLY;
            end
            cba_pkg::S_REPLY:
            begin
                // reply cycle also takes the next request
                state_next = accept ? cba_pkg::S_EXEC : cba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cba_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            cba_pkg::S_IDLE:
            begin
            end
            cba_pkg::S_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            cba_pkg::S_REPLY:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
        cmd.load = start && !busy;
    end

endmodule

`default_nettype wire

[hw/rtl/cba_datapath.sv]
// Datapath: request registers, usage bitmap, range mask test and result registers.
`timescale 1ns / 1ps
`default_nettype none

module cba_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cba_pkg::cmd_t              cmd,
    input  wire logic [1:0]                 action,
    input  wire logic [cba_pkg::BLK_W-1:0]  start_block,
    input  wire logic [cba_pkg::LEN_W-1:0]  run_length,
    output logic [1:0]                      status,
    output logic                            block_used
);

    logic [1:0]                        action_reg;
    logic [cba_pkg::BLK_W-1:0]         start_reg;
    logic [cba_pkg::LEN_W-1:0]         len_reg;
    logic [cba_pkg::DISK_BLOCKS-1:0]   map_reg;
    logic [cba_pkg::DISK_BLOCKS-1:0]   map_next;
    cba_pkg::status_t                  status_reg;
    cba_pkg::status_t                  status_next;
    logic                              used_reg;
    logic                              used_next;

    logic [cba_pkg::SUM_W-1:0]         range_end;
    logic                              in_range;
    logic                              query_ok;
    logic [cba_pkg::DISK_BLOCKS-1:0]   mask;
    logic [cba_pkg::DISK_BLOCKS-1:0]   hit;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            start_reg  <= start_block;
            len_reg    <= run_length;
        end
    end

    // Range bounds and mask
    assign range_end = cba_pkg::SUM_W'(start_reg) + cba_pkg::SUM_W'(len_reg);
    assign in_range  = range_end <= cba_pkg::SUM_W'(cba_pkg::DISK_BLOCKS);
    assign query_ok  = cba_pkg::SUM_W'(start_reg) < cba_pkg::SUM_W'(cba_pkg::DISK_BLOCKS);

    always_comb
    begin
        for (int i = 0; i < cba_pkg::DISK_BLOCKS; i++)
        begin
            mask[i] = (cba_pkg::SUM_W'(i) >= cba_pkg::SUM_W'(start_reg)) &&
                      (cba_pkg::SUM_W'(i) < range_end);
        end
    end

    assign hit = map_reg & mask;

    // Check and update
    always_comb
    begin
        map_next    = map_reg;
        status_next = cba_pkg::ST_DONE;
        used_next   = 1'b0;
        case (cba_pkg::action_t'(action_reg))
            cba_pkg::ACT_ALLOC:
            begin
                if (!in_range)
                    status_next = cba_pkg::ST_RANGE;
                else if (hit != '0)
                    status_next = cba_pkg::ST_CONFLICT;
                else
                    map_next = map_reg | mask;
            end
            cba_pkg::ACT_RELEASE:
            begin
                if (!in_range)
                    status_next = cba_pkg::ST_RANGE;
                else if (hit != mask)
                    status_next = cba_pkg::ST_CONFLICT;
                else
                    map_next = map_reg & ~mask;
            end
            cba_pkg::ACT_QUERY:
            begin
                if (!query_ok)
                    status_next = cba_pkg::ST_RANGE;
                else
                    used_next = map_reg[start_reg];
            end
            default:
            begin
            end
        endcase
    end

    // Bitmap: all blocks free after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else if (cmd.exec)
        begin
            map_reg <= map_next;
        end
    end

    // Result beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            used_reg   <= used_next;
        end
    end

    assign status     = status_reg;
    assign block_used = used_reg;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the contiguous block allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;

    import cba_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Expected result of one request
    typedef struct packed {
        status_t status;
        logic    used;
    } alloc_result_t;

    // A range known to be allocated, kept so that releases can hit it exactly
    typedef struct {
        logic [BLK_W-1:0] blk;
        logic [LEN_W-1:0] len;
    } block_run_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic [1:0]       action      = ACT_NONE;
    logic [BLK_W-1:0] start_block = '0;
    logic [LEN_W-1:0] run_length  = '0;
    logic             busy;
    logic             done;
    logic [1:0]       status;
    logic             block_used;

    logic [DISK_BLOCKS-1:0] usage_map = '0;
    alloc_result_t          pending_results[$];
    block_run_t             live_runs[$];
    int                     idle_pct    = 0;
    int                     error_count = 0;
    int                     quiet_cycles = 0;

    contiguous_block_allocator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .start_block (start_block),
        .run_length  (run_length),
        .done        (done),
        .status      (status),
        .block_used  (block_used)
    );

    always #5 clk = ~clk;

    // Bitmap predictor: applies one request and returns its result
    function automatic alloc_result_t predict_request(action_t act, logic [BLK_W-1:0] blk,
                                                      logic [LEN_W-1:0] len);
        alloc_result_t          r;
        logic [DISK_BLOCKS-1:0] mask;
        r.status = ST_DONE;
        r.used   = 1'b0;
        mask     = '0;
        case (act)
            ACT_ALLOC, ACT_RELEASE:
            begin
                if (int'(blk) + int'(len) > DISK_BLOCKS)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    if (len >= 64)
                        mask = '1;
                    else if (len != 0)
                        mask = (64'd1 << len) - 64'd1;
                    mask = mask << blk;
                    if (act == ACT_ALLOC)
                    begin
                        if ((usage_map & mask) != '0)
                            r.status = ST_CONFLICT;
                        else
                            usage_map = usage_map | mask;
                    end
                    else
                    begin
                        if ((usage_map & mask) != mask)
                            r.status = ST_CONFLICT;
                        else
                            usage_map = usage_map & ~mask;
                    end
                end
            end
            ACT_QUERY:
            begin
                if (int'(blk) >= DISK_BLOCKS)
                    r.status = ST_RANGE;
                else
                    r.used = usage_map[blk];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Send one request beat, record its expectation, then idle at random
    task automatic send_request(action_t act, logic [BLK_W-1:0] blk, logic [LEN_W-1:0] len);
        alloc_result_t r;
        block_run_t    run;
        start       <= 1'b1;
        action      <= act;
        start_block <= blk;
        run_length  <= len;
        do
            @(posedge clk);
        while (busy);
        r = predict_request(act, blk, len);
        pending_results.push_back(r);
        if (act == ACT_ALLOC && r.status == ST_DONE && len != 0)
        begin
            run.blk = blk;
            run.len = len;
            live_runs.push_back(run);
        end
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // Result checker: every done beat against the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request pending: status=%0d block_used=%0d",
                       status, block_used);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    error_count++;
                end
                if (block_used !== exp_r.used)
                begin
                    $error("block_used: expected %0d, got %0d", exp_r.used, block_used);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("contiguous_block_allocator_top regression: fail");
            $finish;
        end
    end

    // Fresh map: queries read free blocks, release of free block conflicts
    task automatic test_empty_map();
        send_request(ACT_QUERY, 6'd0, 7'd0);
        send_request(ACT_QUERY, 6'd63, 7'd127);
        send_request(ACT_RELEASE, 6'd0, 7'd1);
    endtask

    // Whole disk in one run
    task automatic test_full_disk();
        send_request(ACT_ALLOC, 6'd0, 7'd64);
        send_request(ACT_QUERY, 6'd63, 7'd0);
        send_request(ACT_QUERY, 6'd0, 7'd0);
        send_request(ACT_ALLOC, 6'd31, 7'd1);
        send_request(ACT_RELEASE, 6'd0, 7'd64);
        send_request(ACT_QUERY, 6'd0, 7'd0);
    endtask

    // Ranges past the disk end, and ranges ending exactly at it
    task automatic test_range_end();
        send_request(ACT_ALLOC, 6'd63, 7'd2);
        send_request(ACT_ALLOC, 6'd0, 7'd127);
        send_request(ACT_RELEASE, 6'd1, 7'd64);
        send_request(ACT_ALLOC, 6'd1, 7'd63);
        send_request(ACT_QUERY, 6'd63, 7'd0);
        send_request(ACT_RELEASE, 6'd0, 7'd64);
        send_request(ACT_RELEASE, 6'd1, 7'd63);
    endtask

    // Zero-length ranges change nothing
    task automatic test_empty_range();
        send_request(ACT_ALLOC, 6'd5, 7'd0);
        send_request(ACT_RELEASE, 6'd63, 7'd0);
        send_request(ACT_ALLOC, 6'd63, 7'd1);
        send_request(ACT_RELEASE, 6'd63, 7'd0);
        send_request(ACT_RELEASE, 6'd63, 7'd1);
    endtask

    // Unused action code
    task automatic test_unused_action();
        send_request(ACT_NONE, 6'd63, 7'd127);
        send_request(ACT_NONE, 6'd0, 7'd0);
    endtask

    // Mostly short runs, a few long ones reaching the top length bit
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return LEN_W'($urandom_range(8, 0));
        else if (r < 92)
            return LEN_W'($urandom_range(40, 9));
        else
            return LEN_W'($urandom_range(127, 41));
    endfunction

    // Random churn of allocations and releases with queries and unused action codes in between
    task automatic test_random(int count, int pct);
        int               roll;
        int               idx;
        logic [BLK_W-1:0] blk;
        logic [LEN_W-1:0] len;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            blk  = BLK_W'($urandom_range(63, 0));
            len  = pick_length();
            if (roll >= 40 && roll < 65 && live_runs.size() > 0)
            begin
                idx = $urandom_range(live_runs.size() - 1, 0);
                blk = live_runs[idx].blk;
                len = live_runs[idx].len;
                live_runs.delete(idx);
                send_request(ACT_RELEASE, blk, len);
            end
            else if (roll < 65)
                send_request(ACT_ALLOC, blk, len);
            else if (roll < 75)
                send_request(ACT_RELEASE, blk, len);
            else if (roll < 95)
                send_request(ACT_QUERY, blk, len);
            else
                send_request(ACT_NONE, blk, len);
        end
        idle_pct = 0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_map();
        test_full_disk();
        test_range_end();
        test_empty_range();
        test_unused_action();

        test_random(463, 0);
        test_random(463, 83);
        test_random(463, 36);
        test_random(463, 0);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("contiguous_block_allocator_top regression: pass");
        else
            $display("contiguous_block_allocator_top regression: fail");
        $finish;
    end

endmodule

[contiguous_block_allocator_top.f]
hw/rtl/cba_pkg.sv
hw/rtl/cba_ctrl.sv
hw/rtl/cba_datapath.sv
hw/rtl/contiguous_block_allocator_top.sv
tb/testbench.sv
